FILE: sv/assert_macros.svh
// Assertion macros for the link checker; clock is clk, reset is rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_RST(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: sv/pel_pkg.sv
// Shared types and constants of the panel EEPROM read link.
package pel_pkg;

  localparam int ADDR_LIMIT_DEF = 512;

  // input selectors
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // result kinds
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // register indexes
  localparam logic [1:0] REG_LINK_ENABLED = 2'd0;
  localparam logic [1:0] REG_FIRST_WAIT   = 2'd1;
  localparam logic [1:0] REG_GAP_WAIT     = 2'd2;
  localparam logic [1:0] REG_MAX_TRIES    = 2'd3;

  localparam logic       RST_LINK_ENABLED = 1'b1;
  localparam logic [3:0] RST_FIRST_WAIT   = 4'd10;
  localparam logic [3:0] RST_GAP_WAIT     = 4'd5;
  localparam logic [1:0] RST_MAX_TRIES    = 2'd3;

  // query framing and response check
  localparam logic [7:0] Q_SYNC  = 8'h00;
  localparam logic [7:0] Q_LEN   = 8'h02;
  localparam logic [7:0] Q_READ  = 8'hD2;
  localparam logic [7:0] Q_END   = 8'h03;
  localparam logic [7:0] RESP_CODE = 8'hD1;
  localparam logic [7:0] RESP_LEN  = 8'd5;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W  = 4;

  // one pending run of results handed from the core to the emitter
  typedef struct packed {
    logic        valid;
    logic        query;   // six query bytes, else one done result
    logic        ok;
    logic [7:0]  data;
    logic [15:0] addr;
  } burst_t;

endpackage

FILE: sv/pel_core.sv
// Request state, response capture and configuration registers of the link.
module pel_core #(
  parameter int ADDR_LIMIT = pel_pkg::ADDR_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [pel_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_fire,
  input  logic [1:0]                    command,
  input  logic [15:0]                   address,
  input  logic [7:0]                    rx_byte,
  output pel_pkg::burst_t               burst
);

  localparam int ADDR_W = (ADDR_LIMIT > 1) ? $clog2(ADDR_LIMIT) : 1;

  logic             link_enabled;
  logic [3:0]       first_wait;
  logic [3:0]       gap_wait;
  logic [1:0]       max_tries;

  logic             busy, busy_next;
  logic [1:0]       tries_left, tries_left_next;
  logic [3:0]       wait_left, wait_left_next;
  logic [7:0]       rx_count, rx_count_next;
  logic [7:0]       code_byte, code_byte_next;
  logic [7:0]       data_byte, data_byte_next;
  logic [ADDR_W-1:0] held_address, held_address_next;

  logic             addr_ok;
  logic [1:0]       tries_dec;
  logic [15:0]      held_ext;

  assign addr_ok   = {1'b0, address} < 17'(ADDR_LIMIT);
  assign tries_dec = (tries_left != 2'd0) ? tries_left - 2'd1 : 2'd0;
  assign held_ext  = 16'(held_address);

  always_ff @(posedge clk) begin
    if (rst) begin
      link_enabled <= pel_pkg::RST_LINK_ENABLED;
      first_wait   <= pel_pkg::RST_FIRST_WAIT;
      gap_wait     <= pel_pkg::RST_GAP_WAIT;
      max_tries    <= pel_pkg::RST_MAX_TRIES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pel_pkg::REG_LINK_ENABLED: link_enabled <= cfg_data[0];
        pel_pkg::REG_FIRST_WAIT:   first_wait   <= cfg_data[3:0];
        pel_pkg::REG_GAP_WAIT:     gap_wait     <= cfg_data[3:0];
        pel_pkg::REG_MAX_TRIES:    max_tries    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    busy_next         = busy;
    tries_left_next   = tries_left;
    wait_left_next    = wait_left;
    rx_count_next     = rx_count;
    code_byte_next    = code_byte;
    data_byte_next    = data_byte;
    held_address_next = held_address;
    burst             = '0;
    if (in_fire) begin
      unique case (command)
        pel_pkg::CMD_START: begin
          if (!busy) begin
            burst.valid = 1'b1;
            if (!link_enabled || !addr_ok) begin
              burst.query = 1'b0;
            end else begin
              busy_next         = 1'b1;
              held_address_next = address[ADDR_W-1:0];
              tries_left_next   = (max_tries == 2'd0) ? 2'd1 : max_tries;
              rx_count_next     = 8'd0;
              wait_left_next    = first_wait;
              burst.query       = 1'b1;
              burst.addr        = address;
            end
          end
        end
        pel_pkg::CMD_BYTE: begin
          if (busy) begin
            if (rx_count == 8'd2) code_byte_next = rx_byte;
            else if (rx_count == 8'd3) data_byte_next = rx_byte;
            if (rx_count != 8'hFF) rx_count_next = rx_count + 8'd1;
            wait_left_next = gap_wait;
          end
        end
        pel_pkg::CMD_TICK: begin
          if (busy) begin
            if (wait_left != 4'd0) begin
              wait_left_next = wait_left - 4'd1;
            end else begin
              tries_left_next = tries_dec;
              burst.valid     = 1'b1;
              if (rx_count == 8'd0 && tries_dec != 2'd0) begin
                // nothing came back: send the query again
                burst.query    = 1'b1;
                burst.addr     = held_ext;
                wait_left_next = first_wait;
              end else begin
                busy_next  = 1'b0;
                burst.ok   = (rx_count == pel_pkg::RESP_LEN) &&
                             (code_byte == pel_pkg::RESP_CODE);
                burst.data = burst.ok ? data_byte : 8'd0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      tries_left   <= 2'd0;
      wait_left    <= 4'd0;
      rx_count     <= 8'd0;
      code_byte    <= 8'd0;
      data_byte    <= 8'd0;
      held_address <= '0;
    end else begin
      busy         <= busy_next;
      tries_left   <= tries_left_next;
      wait_left    <= wait_left_next;
      rx_count     <= rx_count_next;
      code_byte    <= code_byte_next;
      data_byte    <= data_byte_next;
      held_address <= held_address_next;
    end
  end

endmodule

FILE: sv/pel_emit.sv
// Result register and beat sequencer for query bytes and done results.
module pel_emit (
  input  logic                            clk,
  input  logic                            rst,
  input  pel_pkg::burst_t                 burst,
  output logic                            free,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pel_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tuser,
  output logic                            m_tlast
);

  localparam logic [2:0] LAST_QUERY_BEAT = 3'd5;

  logic        pending;
  logic [2:0]  beat_idx;
  logic        query;
  logic        ok;
  logic [7:0]  data;
  logic [15:0] addr;
  logic        final_beat;
  logic [7:0]  tx_byte;

  assign final_beat = !query || (beat_idx == LAST_QUERY_BEAT);
  assign free       = !pending || (m_tready && final_beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= 1'b0;
      beat_idx <= 3'd0;
    end else if (burst.valid) begin
      pending  <= 1'b1;
      beat_idx <= 3'd0;
    end else if (pending && m_tready) begin
      if (final_beat) pending <= 1'b0;
      else beat_idx <= beat_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst.valid) begin
      query <= burst.query;
      ok    <= burst.ok;
      data  <= burst.data;
      addr  <= burst.addr;
    end
  end

  always_comb begin
    unique case (beat_idx)
      3'd0:    tx_byte = pel_pkg::Q_SYNC;
      3'd1:    tx_byte = pel_pkg::Q_LEN;
      3'd2:    tx_byte = pel_pkg::Q_READ;
      3'd3:    tx_byte = addr[15:8];
      3'd4:    tx_byte = addr[7:0];
      default: tx_byte = pel_pkg::Q_END;
    endcase
    if (!query) tx_byte = 8'd0;
  end

  assign m_tvalid = pending;
  assign m_tuser  = query ? pel_pkg::KIND_TX : pel_pkg::KIND_DONE;
  assign m_tlast  = final_beat;
  assign m_tdata  = {7'd0, (query ? 8'd0 : data), (!query && ok), tx_byte};

endmodule

FILE: sv/panel_eeprom_read_link.sv
// Top level of the panel EEPROM read link: request core and result emitter.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    tuser command, tdata address, rx_byte
//   m_*      out  m_tvalid/m_tready    tuser kind, tlast last, tdata result
//   cfg_*    in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// One input beat per cycle while s_tready is high: the core updates its state
// in the accepting cycle and hands any results to the emitter's result register.
// A start or a retry queues six query beats; input is held off until the
// last of them is taken. A done result is one beat. Stalls on m_* hold the
// current beat and back up into s_tready. Synchronous reset (rst) restores
// the register defaults and idles the link; configuration is always ready.
module panel_eeprom_read_link #(
  parameter int ADDR_LIMIT = pel_pkg::ADDR_LIMIT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pel_pkg::IN_TDATA_W-1:0]   s_tdata,  // address[15:0], rx_byte[23:16]
  input  logic [1:0]                       s_tuser,  // command[1:0]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pel_pkg::OUT_TDATA_W-1:0]  m_tdata,  // tx_byte[7:0], success[8],
                                                     // read_data[16:9], zero[23:17]
  output logic                             m_tuser,  // kind[0]
  output logic                             m_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [pel_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pel_pkg::burst_t burst;
  logic            free;
  logic            in_fire;

  // Accept a new beat when the result register is empty or drains now.
  assign s_tready  = free;
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  pel_core #(
    .ADDR_LIMIT(ADDR_LIMIT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .command   (s_tuser),
    .address   (s_tdata[15:0]),
    .rx_byte   (s_tdata[23:16]),
    .burst     (burst)
  );

  // Hold each result beat until the downstream side takes it.
  pel_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .burst    (burst),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: sv/pel_checker.sv
// Port-level checks of the link's result channel, bound to the top level.
`include "assert_macros.svh"

module pel_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pel_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tuser,
  input logic                            m_tlast
);

  `ASSERT_NEXT_RST(a_idle_after_reset, rst, !m_tvalid)
  `ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ASSERT_NOW(a_done_is_last, m_tvalid && m_tuser, m_tlast)
  `ASSERT_NEXT(a_query_continues, m_tvalid && m_tready && !m_tuser && !m_tlast, m_tvalid)
  `ASSERT_NOW(a_fail_no_data, m_tvalid && !m_tdata[8], m_tdata[16:9] == 8'd0)

endmodule

bind panel_eeprom_read_link pel_checker u_pel_checker (.*);
